/* design/tka_pkg.sv */
// Shared types and constants for the top-k accuracy counter.
// No dependencies; imported by the top level.
package tka_pkg;

	localparam int CFG_W     = 11;
	localparam int LABEL_W   = 10;
	localparam int OUT_CNT_W = 16;
	localparam int ACC_W     = 17;
	localparam int OUT_BITS  = 1 + OUT_CNT_W + OUT_CNT_W + ACC_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] TOP_K_RST   = 11'd1;
	localparam logic [CFG_W-1:0] NUM_CLS_RST = 11'd1024;

	typedef enum logic [0:0] {
		REG_TOP_K       = 1'b0,
		REG_NUM_CLASSES = 1'b1
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_TRUTH = 7'b0000010,
		ST_WALK  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_TALLY = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

endpackage

/* design/tka_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tka_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/top_k_accuracy_counter.sv */
// Top-k accuracy counter: stores each row of scores, then counts outscoring classes.
// Depends on tka_pkg and tka_ram.
// A score that does not end a row is taken while idle and stored. A row end reads the true
// class, reads each class in turn, then tallies and emits the result, with a bit-serial
// accuracy divider on a batch's last row; a bad label skips the reads and goes to the tally.
// s_tready stays low from a row end until the result is emitted, so no score is taken meanwhile.
// Reset clears position, counters and control; the row store is not cleared.
module top_k_accuracy_counter #(
	parameter int MAX_CLASSES = 1024,
	parameter int SCORE_WIDTH = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  tka_pkg::cfg_reg_t              wr_index,
	input  logic [tka_pkg::CFG_W-1:0]      wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// score, true_label, zero fill
	input  logic [((SCORE_WIDTH + tka_pkg::LABEL_W + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// row_hit, hit_total, row_total, accuracy, zero fill
	output logic [tka_pkg::OUT_W-1:0]      m_tdata,
	// label_bad
	output logic                           m_tuser,
	output logic                           m_tlast
);

	import tka_pkg::*;

	localparam int AW   = $clog2(MAX_CLASSES);
	localparam int NW   = ($clog2(MAX_CLASSES + 1) > CFG_W) ? $clog2(MAX_CLASSES + 1) : CFG_W;
	localparam int CW   = COUNT_WIDTH;
	localparam int NUMW = CW + ACC_W;

	state_t                  state_q;
	logic [CFG_W-1:0]        top_k_q;
	logic [CFG_W-1:0]        num_classes_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           idx_q;
	logic [LABEL_W-1:0]      label_q;
	logic                    batch_q;
	logic                    bad_q;
	logic                    hit_q;
	logic [NW-1:0]           above_q;
	logic [SCORE_WIDTH-1:0]  truth_q;
	logic                    truth_s1;
	logic                    rd_s1;
	logic [CW-1:0]           hit_cnt_q;
	logic [CW-1:0]           row_cnt_q;
	logic [CW-1:0]           rem_q;
	logic [ACC_W-1:0]        quo_q;
	logic [4:0]              div_cnt_q;
	logic [OUT_W-1:0]        m_tdata_q;
	logic                    m_tvalid_q;
	logic                    m_tuser_q;
	logic                    m_tlast_q;

	logic                    s_accept;
	logic [NW-1:0]           ncfg;
	logic [NW-1:0]           n_eff;
	logic [NW-1:0]           pos_p1;
	logic                    row_end;
	logic [SCORE_WIDTH-1:0]  score_in;
	logic [LABEL_W-1:0]      label_in;
	logic                    label_bad_in;
	logic [AW-1:0]           raddr;
	logic [SCORE_WIDTH-1:0]  rdata;
	logic                    hit_now;
	logic [CW-1:0]           row_next;
	logic [CW-1:0]           hit_next;
	logic [NUMW-1:0]         numer;
	logic [CW:0]             div_t;
	logic                    div_ge;
	logic [CW:0]             div_sub;
	logic                    out_free;
	logic [CW+OUT_CNT_W-1:0] hit_ext;
	logic [CW+OUT_CNT_W-1:0] row_ext;
	logic [ACC_W-1:0]        acc_out;

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign score_in = s_tdata[SCORE_WIDTH-1:0];
	assign label_in = s_tdata[SCORE_WIDTH +: LABEL_W];

	always_comb begin
		ncfg = NW'(num_classes_q);
		if (ncfg == '0) begin
			n_eff = NW'(1);
		end else if (ncfg > NW'(MAX_CLASSES)) begin
			n_eff = NW'(MAX_CLASSES);
		end else begin
			n_eff = ncfg;
		end
	end

	assign pos_p1       = NW'(pos_q) + NW'(1);
	assign row_end      = (pos_p1 >= n_eff);
	assign label_bad_in = (NW'(label_in) >= n_eff);

	assign raddr = (state_q == ST_TRUTH) ? AW'(label_q) : idx_q;

	tka_ram #(
		.WIDTH(SCORE_WIDTH),
		.DEPTH(MAX_CLASSES)
	) u_row_store (
		.clk  (clk),
		.we   (s_accept),
		.waddr(pos_q),
		.wdata(score_in),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign hit_now  = !bad_q && (above_q < NW'(top_k_q));
	assign row_next = (row_cnt_q == '1) ? row_cnt_q : row_cnt_q + CW'(1);
	assign hit_next = (hit_now && (hit_cnt_q < row_next)) ? hit_cnt_q + CW'(1) : hit_cnt_q;
	assign numer    = {1'b0, hit_next, {(ACC_W - 1){1'b0}}} + NUMW'(row_next >> 1);

	assign div_t   = {rem_q, quo_q[ACC_W-1]};
	assign div_ge  = (div_t >= {1'b0, row_cnt_q});
	assign div_sub = div_t - {1'b0, row_cnt_q};

	assign out_free = !m_tvalid_q || m_tready;
	assign hit_ext  = {{OUT_CNT_W{1'b0}}, hit_cnt_q};
	assign row_ext  = {{OUT_CNT_W{1'b0}}, row_cnt_q};
	assign acc_out  = batch_q ? quo_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q       <= TOP_K_RST;
			num_classes_q <= NUM_CLS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TOP_K:       top_k_q       <= wr_data;
				REG_NUM_CLASSES: num_classes_q <= wr_data;
				default:         top_k_q       <= top_k_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			idx_q      <= '0;
			above_q    <= '0;
			truth_s1   <= 1'b0;
			rd_s1      <= 1'b0;
			hit_cnt_q  <= '0;
			row_cnt_q  <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			truth_s1 <= (state_q == ST_TRUTH);
			rd_s1    <= (state_q == ST_WALK);
			if (rd_s1 && ($signed(rdata) > $signed(truth_q))) begin
				above_q <= above_q + NW'(1);
			end
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (row_end) begin
							pos_q   <= '0;
							idx_q   <= '0;
							above_q <= '0;
							state_q <= label_bad_in ? ST_TALLY : ST_TRUTH;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
					end
				end
				ST_TRUTH: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					idx_q <= idx_q + AW'(1);
					if (NW'(idx_q) + NW'(1) >= n_eff) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_TALLY;
				end
				ST_TALLY: begin
					row_cnt_q <= row_next;
					hit_cnt_q <= hit_next;
					div_cnt_q <= '0;
					state_q   <= batch_q ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(ACC_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (batch_q) begin
							hit_cnt_q <= '0;
							row_cnt_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (truth_s1) begin
			truth_q <= rdata;
		end
		if (s_accept && row_end) begin
			label_q <= label_in;
			batch_q <= s_tlast;
			bad_q   <= label_bad_in;
		end
		case (state_q)
			ST_TALLY: begin
				hit_q <= hit_now;
				rem_q <= numer[NUMW-1:ACC_W];
				quo_q <= numer[ACC_W-1:0];
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[CW-1:0] : div_t[CW-1:0];
				quo_q <= {quo_q[ACC_W-2:0], div_ge};
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= OUT_W'({acc_out, row_ext[OUT_CNT_W-1:0],
						hit_ext[OUT_CNT_W-1:0], hit_q});
					m_tuser_q <= bad_q;
					m_tlast_q <= batch_q;
				end
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cnt_q <= row_cnt_q)
		else $error("hit counter exceeds row counter");

	a_row_end_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && row_end |=> state_q != ST_IDLE)
		else $error("row end did not start the count");

	a_acc_only_on_batch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[OUT_BITS-1:OUT_BITS-ACC_W] == '0)
		else $error("accuracy nonzero outside a batch end");

	a_bad_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0])
		else $error("bad label reported as hit");

endmodule

/* sim/tb_top_k_accuracy_counter.sv */
// Self-checking testbench for top_k_accuracy_counter: streams score rows, predicts each
// row result and batch accuracy in a scoreboard class, and compares every result transfer.
// Depends on tka_pkg and the top_k_accuracy_counter RTL.
module tb_top_k_accuracy_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import tka_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_SCORES = 1350;

	typedef enum int {
		MIX_WIDE,
		MIX_TIES,
		MIX_EDGES
	} score_mix_t;

	typedef struct packed {
		logic        row_hit;
		logic        label_bad;
		logic [15:0] hit_total;
		logic [15:0] row_total;
		logic [16:0] accuracy;
		logic        batch_done;
	} row_result_t;

	class accuracy_scoreboard;
		logic signed [15:0] stored_scores [1024];
		int unsigned        column;
		int unsigned        hits_so_far;
		int unsigned        row_count;
		logic [10:0]        top_k_reg;
		logic [10:0]        classes_reg;
		row_result_t        expected_rows [$];
		int unsigned        faults;
		int unsigned        checked;
		int unsigned        batches;
		int unsigned        bad_labels;

		function new();
			column = 0;
			hits_so_far = 0;
			row_count = 0;
			top_k_reg = TOP_K_RST;
			classes_reg = NUM_CLS_RST;
			faults = 0;
			checked = 0;
			batches = 0;
			bad_labels = 0;
		endfunction

		function void set_regs(logic [10:0] k, logic [10:0] classes);
			top_k_reg = k;
			classes_reg = classes;
		endfunction

		function int unsigned pending();
			return expected_rows.size();
		endfunction

		function void note_score(logic signed [15:0] score, logic [9:0] label, logic batch_end);
			int unsigned row_len;
			int unsigned above;
			longint unsigned ratio;
			row_result_t r;
			row_len = (classes_reg == 0) ? 1 : ((classes_reg > 1024) ? 1024 : classes_reg);
			stored_scores[column] = score;
			if (column + 1 < row_len) begin
				column++;
				return;
			end
			column = 0;
			r = '0;
			r.label_bad = (label >= row_len);
			if (!r.label_bad) begin
				above = 0;
				for (int i = 0; i < row_len; i++)
					if (stored_scores[i] > stored_scores[label])
						above++;
				r.row_hit = (above < top_k_reg);
			end
			if (row_count < 65535)
				row_count++;
			if (r.row_hit && hits_so_far < row_count)
				hits_so_far++;
			r.hit_total = hits_so_far[15:0];
			r.row_total = row_count[15:0];
			r.batch_done = batch_end;
			if (batch_end) begin
				ratio = ((longint'(hits_so_far) << 16) + (row_count >> 1)) / row_count;
				if (ratio > 65536)
					ratio = 65536;
				r.accuracy = ratio[16:0];
				hits_so_far = 0;
				row_count = 0;
			end
			expected_rows.push_back(r);
		endfunction

		function void check_row(logic [OUT_W-1:0] data, logic bad, logic done);
			row_result_t got;
			row_result_t want;
			got.row_hit = data[0];
			got.label_bad = bad;
			got.hit_total = data[16:1];
			got.row_total = data[32:17];
			got.accuracy = data[49:33];
			got.batch_done = done;
			if (expected_rows.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("Unexpected row result: hit=%0d bad=%0d hits=%0d rows=%0d acc=%0d done=%0d",
						got.row_hit, got.label_bad, got.hit_total, got.row_total,
						got.accuracy, got.batch_done);
				return;
			end
			want = expected_rows.pop_front();
			checked++;
			if (want.batch_done)
				batches++;
			if (want.label_bad)
				bad_labels++;
			if (got !== want) begin
				faults++;
				if (faults <= 10) begin
					$display("Row result %0d differs at %0t:", checked, $realtime);
					$display("  expected hit=%0d bad=%0d hits=%0d rows=%0d acc=%0d done=%0d",
						want.row_hit, want.label_bad, want.hit_total, want.row_total,
						want.accuracy, want.batch_done);
					$display("  actual   hit=%0d bad=%0d hits=%0d rows=%0d acc=%0d done=%0d",
						got.row_hit, got.label_bad, got.hit_total, got.row_total,
						got.accuracy, got.batch_done);
				end
			end
		endfunction

		function void close_out();
			if (expected_rows.size() != 0 && faults < 10)
				$display("%0d expected row results never arrived.", expected_rows.size());
			faults += expected_rows.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en = 1'b0;
	cfg_reg_t         wr_index = REG_TOP_K;
	logic [CFG_W-1:0] wr_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;
	logic             m_tlast;

	accuracy_scoreboard board = new();
	bit                 gaps_on = 1'b1;
	int unsigned        scores_sent = 0;
	int unsigned        quiet_cycles = 0;

	top_k_accuracy_counter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!gaps_on)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) >= 38);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_row(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("No transfer for %0d cycles; giving up.", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic program_regs(input logic [10:0] k, input logic [10:0] classes);
		wr_en <= 1'b1;
		wr_index <= REG_TOP_K;
		wr_data <= k;
		@(posedge clk);
		wr_index <= REG_NUM_CLASSES;
		wr_data <= classes;
		@(posedge clk);
		wr_en <= 1'b0;
		board.set_regs(k, classes);
	endtask

	task automatic send_score(input logic [15:0] score, input logic [9:0] label,
		input logic batch_end);
		while (gaps_on && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, label, score};
		s_tlast <= batch_end;
		do @(posedge clk); while (!s_tready);
		board.note_score(score, label, batch_end);
		scores_sent++;
	endtask

	task automatic send_row(input int unsigned len, input logic [9:0] label,
		input logic batch_end, input score_mix_t mix, input bit noisy);
		logic [15:0] sc;
		logic [9:0]  lab;
		logic        flag;
		for (int i = 0; i < len; i++) begin
			case (mix)
				MIX_TIES: sc = 16'($urandom_range(0, 4) - 2);
				MIX_EDGES: begin
					case ($urandom_range(0, 3))
						0: sc = 16'h8000;
						1: sc = 16'h7fff;
						2: sc = 16'h0000;
						default: sc = 16'hffff;
					endcase
				end
				default: sc = 16'($urandom);
			endcase
			if (i == len - 1) begin
				lab = label;
				flag = batch_end;
			end else begin
				lab = noisy ? 10'($urandom_range(0, 1023)) : label;
				flag = ($urandom_range(0, 4) == 0);
			end
			send_score(sc, lab, flag);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int          edge_scores [4];
		int unsigned phase;
		int unsigned row_len;
		int unsigned rows;
		logic [10:0] classes;
		logic [10:0] k;
		logic [9:0]  label;
		bit          big_done;
		score_mix_t  mix;

		edge_scores = '{-32768, 32767, 0, -1};
		phase = 0;
		big_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the score range, ties, and out-of-range labels.
		program_regs(11'd1, 11'd4);
		for (int i = 0; i < 4; i++)
			send_score(16'(edge_scores[i]), 10'd1, 1'b0);
		for (int i = 0; i < 4; i++)
			send_score(16'(edge_scores[i]), 10'd0, 1'b0);
		for (int i = 0; i < 4; i++)
			send_score(16'sd5, 10'd2, 1'b0);
		for (int i = 0; i < 3; i++)
			send_score(16'(edge_scores[i]), 10'd1023, 1'b1);
		send_score(16'sd7, 10'd4, 1'b1);
		settle();

		// A zero class count acts as one; a zero top_k misses every row.
		program_regs(11'd0, 11'd0);
		send_score(16'h1234, 10'd0, 1'b0);
		send_score(16'h8000, 10'd1, 1'b0);
		send_score(16'h7fff, 10'd0, 1'b1);
		settle();

		// The class count shrinks in the middle of a row.
		program_regs(11'd2047, 11'd6);
		send_score(16'sd100, 10'd0, 1'b0);
		send_score(16'sd200, 10'd0, 1'b0);
		send_score(16'sd300, 10'd0, 1'b0);
		settle();
		program_regs(11'd1, 11'd2);
		send_score(16'sd50, 10'd1, 1'b1);
		settle();

		while (scores_sent < RANDOM_SCORES) begin
			phase++;
			gaps_on = !(phase >= 5 && phase <= 8);
			if (!big_done && scores_sent > 600) begin
				classes = 11'd2047;
				big_done = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0: classes = 11'd0;
					1: classes = 11'd1;
					9: classes = 11'($urandom_range(13, 64));
					default: classes = 11'($urandom_range(2, 12));
				endcase
			end
			row_len = (classes == 0) ? 1 : ((classes > 1024) ? 1024 : classes);
			case ($urandom_range(0, 5))
				0: k = 11'd0;
				1: k = 11'd1;
				2: k = 11'($urandom_range(1, row_len + 1));
				3: k = 11'd2047;
				default: k = 11'($urandom_range(1, 4));
			endcase
			program_regs(k, classes);
			rows = (row_len == 1024) ? 1 : $urandom_range(3, 16);
			for (int r = 0; r < rows; r++) begin
				if ($urandom_range(0, 9) == 0)
					label = 10'($urandom_range(0, 1023));
				else
					label = 10'($urandom_range(0, row_len - 1));
				case ($urandom_range(0, 3))
					0: mix = MIX_TIES;
					1: mix = MIX_EDGES;
					default: mix = MIX_WIDE;
				endcase
				send_row(row_len, label, ($urandom_range(0, 4) == 0), mix,
					($urandom_range(0, 4) == 0));
			end
			settle();
		end

		board.close_out();
		$display("Checked %0d row results in %0d batches from %0d scores; %0d bad labels.",
			board.checked, board.batches, scores_sent, board.bad_labels);
		$display("Rows of 1 to 1024 classes were scored with top_k from 0 to 2047.");
		if (board.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* files.f */
design/tka_pkg.sv
design/tka_ram.sv
design/top_k_accuracy_counter.sv
sim/tb_top_k_accuracy_counter.sv
